// ----- design/sfd_pkg.sv -----
// Shared types, field codes and layout constants for the status frame decoder.
package sfd_pkg;

    // Layout caps for the supported controller builds
    localparam logic [1:0] MAX_MOTORS    = 2'd3;
    localparam logic [2:0] MAX_USB_PORTS = 3'd6;

    // Byte positions and section lengths of the frame
    localparam logic [6:0] POS_MAX      = 7'd127;
    localparam logic [6:0] HEADER_END   = 7'd4;
    localparam logic [6:0] ANALOG_END   = 7'd16;
    localparam logic [6:0] GAP_END      = 7'd18;
    localparam logic [6:0] OVERRIDE_END = 7'd22;
    localparam logic [6:0] MOTOR_BASE   = 7'd30;
    localparam logic [6:0] TAIL_LEN     = 7'd8;
    localparam logic [6:0] TAIL_BYTES   = 7'd6;

    // Field ids
    localparam logic [4:0] FID_SUPPLY       = 5'd0;
    localparam logic [4:0] FID_CTRL_TEMP    = 5'd4;
    localparam logic [4:0] FID_FAN_A_OVR_EN = 5'd6;
    localparam logic [4:0] FID_FAN_B_OVR_EN = 5'd7;
    localparam logic [4:0] FID_FAN_A_OVR_ST = 5'd8;
    localparam logic [4:0] FID_FAN_B_OVR_ST = 5'd9;
    localparam logic [4:0] FID_FAN_A_TARGET = 5'd10;
    localparam logic [4:0] FID_AMBIENT_TEMP = 5'd12;
    localparam logic [4:0] FID_MIRROR_TEMP  = 5'd13;
    localparam logic [4:0] FID_MOTOR_DIR    = 5'd14;
    localparam logic [4:0] FID_MOTOR_LOAD   = 5'd15;
    localparam logic [4:0] FID_MOTOR_POS    = 5'd16;
    localparam logic [4:0] FID_POWER_SW     = 5'd17;
    localparam logic [4:0] FID_FLATBOX_DUTY = 5'd18;
    localparam logic [4:0] FID_I2C_ERRORS   = 5'd24;
    localparam logic [4:0] FID_USB_POWER    = 5'd25;
    localparam logic [4:0] FID_USB_FAIL     = 5'd26;
    localparam logic [4:0] FID_FLAP_STATE   = 5'd27;
    localparam logic [4:0] FID_VERDICT      = 5'd28;

    // Verdict codes
    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_LENGTH     = 2'd1;
    localparam logic [1:0] ERR_GENERATION = 2'd2;

    // Motor direction codes
    localparam logic [31:0] DIR_CW     = 32'd0;
    localparam logic [31:0] DIR_CCW    = 32'd1;
    localparam logic [31:0] DIR_HALTED = 32'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_HW_GEN       = 3'd0;
    localparam logic [2:0] CFG_IF_MAJOR     = 3'd1;
    localparam logic [2:0] CFG_IF_MINOR     = 3'd2;
    localparam logic [2:0] CFG_TEMP_MIN     = 3'd3;
    localparam logic [2:0] CFG_TEMP_MAX     = 3'd4;
    localparam logic [2:0] CFG_TEMP_NOSENSE = 3'd5;

    // Configuration as seen by the front and back ends
    typedef struct packed {
        logic [2:0]  hw_gen;
        logic [7:0]  if_major;
        logic [7:0]  if_minor;
        logic [15:0] temp_min;
        logic [15:0] temp_max;
        logic [15:0] temp_nosense;
    } sfd_cfg_t;

    // One queue entry: an optional completed field and an optional verdict
    typedef struct packed {
        logic        fld_valid;
        logic [4:0]  fld_id;
        logic [2:0]  fld_index;
        logic [31:0] fld_raw;
        logic        vrd_valid;
        logic [6:0]  vrd_count;
        logic [1:0]  vrd_err;
    } sfd_cmd_t;

endpackage

// ----- design/sfd_front.sv -----
// Front end: byte position tracking, field location and accumulation.
module sfd_front
    import sfd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  sfd_cfg_t cfg,
    input  logic     in_valid,
    input  logic [7:0] in_data,
    input  logic     in_end,
    input  logic     q_full,
    output logic     in_ready,
    output logic     push,
    output sfd_cmd_t push_cmd
);

    logic [6:0]  pos_reg, pos_next;
    logic [31:0] acc_reg, acc_next;

    logic       accept;
    logic       gen_ok, power, roles, digital, usbfail;
    logic [1:0] n_mot;
    logic [2:0] n_usb;
    logic [6:0] mot_len, at0, at1, at2, at3, at4, at5, flen;
    logic [6:0] q, r, off_at0, off_at2, off_at3, off_at4, p_hdr, p_ovr, p_fan;
    logic [1:0] mot_idx;
    logic       hit, first, done;
    logic [4:0] id;
    logic [2:0] idx;
    logic [31:0] acc_raw;
    logic [6:0] count;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Layout from the current configuration
    always_comb begin
        gen_ok  = (cfg.hw_gen >= 3'd1) && (cfg.hw_gen <= 3'd4);
        n_mot   = (cfg.hw_gen > 3'd3) ? 2'd3 : ((cfg.hw_gen > 3'd1) ? 2'd2 : 2'd1);
        if (n_mot > MAX_MOTORS) begin
            n_mot = MAX_MOTORS;
        end
        n_usb   = (cfg.hw_gen > 3'd3) ? 3'd6 : ((cfg.hw_gen > 3'd2) ? 3'd2 : 3'd0);
        if (n_usb > MAX_USB_PORTS) begin
            n_usb = MAX_USB_PORTS;
        end
        power   = cfg.hw_gen > 3'd1;
        roles   = (cfg.if_major > 8'd1) || ((cfg.if_major == 8'd1) && (cfg.if_minor >= 8'd1));
        digital = !roles;
        usbfail = cfg.hw_gen == 3'd3;

        // six bytes per motor
        mot_len = 7'({n_mot, 2'b00}) + 7'({n_mot, 1'b0});
        at0  = MOTOR_BASE + mot_len;
        at1  = at0 + (power ? 7'd2 : 7'd0);
        at2  = at1 + (digital ? 7'd4 : 7'd0);
        at3  = at2 + TAIL_LEN;
        at4  = at3 + 7'(n_usb);
        at5  = at4 + (usbfail ? 7'd2 : 7'd0);
        flen = at5 + (roles ? 7'd1 : 7'd0);
    end

    // Field location of the current byte
    always_comb begin
        p_hdr   = pos_reg - HEADER_END;
        p_ovr   = pos_reg - GAP_END;
        p_fan   = pos_reg - OVERRIDE_END;
        q       = pos_reg - MOTOR_BASE;
        off_at0 = pos_reg - at0;
        off_at2 = pos_reg - at2;
        off_at3 = pos_reg - at3;
        off_at4 = pos_reg - at4;
        mot_idx = (q >= 7'd12) ? 2'd2 : ((q >= 7'd6) ? 2'd1 : 2'd0);
        unique case (mot_idx)
            2'd2:    r = q - 7'd12;
            2'd1:    r = q - 7'd6;
            default: r = q;
        endcase

        hit   = 1'b0;
        first = 1'b1;
        done  = 1'b1;
        id    = FID_SUPPLY;
        idx   = 3'd0;
        priority if (pos_reg < HEADER_END) begin
            hit = 1'b0;
        end else if (pos_reg < ANALOG_END) begin
            // two-byte analog readings
            hit   = 1'b1;
            id    = 5'(p_hdr >> 1);
            first = !p_hdr[0];
            done  = p_hdr[0];
        end else if (pos_reg < GAP_END) begin
            hit = 1'b0;
        end else if (pos_reg < OVERRIDE_END) begin
            hit = 1'b1;
            id  = FID_FAN_A_OVR_EN + 5'(p_ovr);
        end else if (pos_reg < MOTOR_BASE) begin
            hit   = 1'b1;
            id    = FID_FAN_A_TARGET + 5'(p_fan >> 1);
            first = !p_fan[0];
            done  = p_fan[0];
        end else if (pos_reg < at0) begin
            // motor block: direction, load, 4-byte position
            hit = 1'b1;
            idx = 3'(mot_idx);
            if (r == 7'd0) begin
                id = FID_MOTOR_DIR;
            end else if (r == 7'd1) begin
                id = FID_MOTOR_LOAD;
            end else begin
                id    = FID_MOTOR_POS;
                first = r == 7'd2;
                done  = r == 7'd5;
            end
        end else if (power && (pos_reg < at1)) begin
            hit = 1'b1;
            id  = FID_POWER_SW;
            idx = off_at0[2:0];
        end else if (digital && (pos_reg < at2)) begin
            hit = 1'b0;
        end else if (pos_reg < (at2 + TAIL_BYTES)) begin
            hit = 1'b1;
            id  = FID_FLATBOX_DUTY + 5'(off_at2);
        end else if (pos_reg < at3) begin
            hit   = 1'b1;
            id    = FID_I2C_ERRORS;
            first = !off_at2[0];
            done  = off_at2[0];
        end else if (pos_reg < at4) begin
            hit = 1'b1;
            id  = FID_USB_POWER;
            idx = off_at3[2:0];
        end else if (pos_reg < at5) begin
            hit = 1'b1;
            id  = FID_USB_FAIL;
            idx = off_at4[2:0];
        end else if (roles && (pos_reg == at5)) begin
            hit = 1'b1;
            id  = FID_FLAP_STATE;
        end else begin
            hit = 1'b0;
        end
    end

    // Accumulator, position and queue entry
    always_comb begin
        acc_raw  = first ? {24'd0, in_data} : {acc_reg[23:0], in_data};
        count    = (pos_reg < POS_MAX) ? (pos_reg + 7'd1) : POS_MAX;

        push_cmd.fld_valid = gen_ok && hit && done;
        push_cmd.fld_id    = id;
        push_cmd.fld_index = idx;
        push_cmd.fld_raw   = acc_raw;
        push_cmd.vrd_valid = in_end;
        push_cmd.vrd_count = count;
        if (!gen_ok) begin
            push_cmd.vrd_err = ERR_GENERATION;
        end else if (count != flen) begin
            push_cmd.vrd_err = ERR_LENGTH;
        end else begin
            push_cmd.vrd_err = ERR_OK;
        end

        push = accept && (push_cmd.fld_valid || in_end);

        acc_next = acc_reg;
        pos_next = pos_reg;
        if (accept) begin
            if (gen_ok && hit) begin
                acc_next = done ? 32'd0 : acc_raw;
            end
            if (in_end) begin
                acc_next = 32'd0;
                pos_next = 7'd0;
            end else if (pos_reg < POS_MAX) begin
                pos_next = pos_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 7'd0;
            acc_reg <= 32'd0;
        end else begin
            pos_reg <= pos_next;
            acc_reg <= acc_next;
        end
    end

endmodule

// ----- design/sfd_queue.sv -----
// Short register queue of decoded entries between front and back ends.
module sfd_queue
    import sfd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  sfd_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output sfd_cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sfd_cmd_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full       = count_reg == FULL_CNT;
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : (wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : (rd_ptr_reg + 1'b1);
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- design/sfd_back.sv -----
// Back end: value conversion, plausibility check and the result output register.
module sfd_back
    import sfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  sfd_cfg_t    cfg,
    input  logic        head_valid,
    input  sfd_cmd_t    head,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_field_id,
    output logic [2:0]  m_field_index,
    output logic signed [31:0] m_field_value,
    output logic        m_plausible,
    output logic [1:0]  m_error_code,
    output logic        m_last
);

    logic        valid_reg, valid_next;
    logic        phase_reg, phase_next;
    logic [4:0]  id_reg, id_next;
    logic [2:0]  index_reg, index_next;
    logic [31:0] value_reg, value_next;
    logic        plaus_reg, plaus_next;
    logic [1:0]  err_reg, err_next;
    logic        last_reg, last_next;

    logic        load;
    logic        send_fld;
    logic [31:0] fld_val;
    logic        fld_plaus;
    logic        is_flag;

    assign m_valid       = valid_reg;
    assign m_field_id    = id_reg;
    assign m_field_index = index_reg;
    assign m_field_value = signed'(value_reg);
    assign m_plausible   = plaus_reg;
    assign m_error_code  = err_reg;
    assign m_last        = last_reg;

    // Value conversion by field kind
    always_comb begin
        is_flag = (head.fld_id == FID_FAN_A_OVR_EN) || (head.fld_id == FID_FAN_B_OVR_EN)
               || (head.fld_id == FID_FAN_A_OVR_ST) || (head.fld_id == FID_FAN_B_OVR_ST)
               || (head.fld_id == FID_POWER_SW) || (head.fld_id == FID_USB_POWER)
               || (head.fld_id == FID_USB_FAIL);
        fld_val = head.fld_raw;
        if (head.fld_id == FID_CTRL_TEMP) begin
            fld_val = {{16{head.fld_raw[15]}}, head.fld_raw[15:0]};
        end else if (is_flag) begin
            fld_val = {31'd0, head.fld_raw != 32'd0};
        end else if (head.fld_id == FID_MOTOR_DIR) begin
            if (head.fld_raw == 32'd0) begin
                fld_val = DIR_CW;
            end else if (head.fld_raw == 32'd1) begin
                fld_val = DIR_CCW;
            end else begin
                fld_val = DIR_HALTED;
            end
        end
        // temperature fields are two bytes, upper half always zero
        fld_plaus = ((head.fld_id == FID_AMBIENT_TEMP) || (head.fld_id == FID_MIRROR_TEMP))
                 && (head.fld_raw[15:0] != cfg.temp_nosense)
                 && (head.fld_raw[15:0] >= cfg.temp_min)
                 && (head.fld_raw[15:0] <= cfg.temp_max);
    end

    // Output register: field beat first, verdict beat second
    always_comb begin
        load       = !valid_reg || m_ready;
        send_fld   = head.fld_valid && !phase_reg;
        valid_next = valid_reg && !m_ready;
        phase_next = phase_reg;
        id_next    = id_reg;
        index_next = index_reg;
        value_next = value_reg;
        plaus_next = plaus_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (head_valid && load) begin
            valid_next = 1'b1;
            if (send_fld) begin
                id_next    = head.fld_id;
                index_next = head.fld_index;
                value_next = fld_val;
                plaus_next = fld_plaus;
                err_next   = ERR_OK;
                last_next  = !head.vrd_valid;
                phase_next = head.vrd_valid;
                pop        = !head.vrd_valid;
            end else begin
                id_next    = FID_VERDICT;
                index_next = 3'd0;
                value_next = {25'd0, head.vrd_count};
                plaus_next = 1'b0;
                err_next   = head.vrd_err;
                last_next  = 1'b1;
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg    <= id_next;
        index_reg <= index_next;
        value_reg <= value_next;
        plaus_reg <= plaus_next;
        err_reg   <= err_next;
        last_reg  <= last_next;
    end

endmodule

// ----- design/status_frame_decoder.sv -----
// Top level of the status frame decoder: configuration registers and the three stages.
// An accepted byte's first result is queued, then loaded into the output register.
// Throughput: one byte per cycle unless the queue is full; a frame's last byte
// completing a field needs two output beats, absorbed by the QUEUE_DEPTH-entry queue.
// Reset (aresetn low, synchronous): configuration returns to its defaults,
// byte position and accumulator clear, the queue and the output register empty.
module status_frame_decoder
    import sfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_frame_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_field_id,
    output logic [2:0]  m_field_index,
    output logic signed [31:0] m_field_value,
    output logic        m_plausible,
    output logic [1:0]  m_error_code,
    output logic        m_last
);

    sfd_cfg_t cfg_reg, cfg_next;
    logic     push, q_full, pop, head_valid;
    sfd_cmd_t push_cmd, head;

    // Configuration write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_HW_GEN:       cfg_next.hw_gen       = cfg_wdata[2:0];
                CFG_IF_MAJOR:     cfg_next.if_major     = cfg_wdata[7:0];
                CFG_IF_MINOR:     cfg_next.if_minor     = cfg_wdata[7:0];
                CFG_TEMP_MIN:     cfg_next.temp_min     = cfg_wdata;
                CFG_TEMP_MAX:     cfg_next.temp_max     = cfg_wdata;
                CFG_TEMP_NOSENSE: cfg_next.temp_nosense = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hw_gen       <= 3'd2;
            cfg_reg.if_major     <= 8'd1;
            cfg_reg.if_minor     <= 8'd0;
            cfg_reg.temp_min     <= 16'd0;
            cfg_reg.temp_max     <= 16'hFFFF;
            cfg_reg.temp_nosense <= 16'hFFFF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Byte tracking and field location
    sfd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_valid),
        .in_data  (s_data_byte),
        .in_end   (s_frame_end),
        .q_full   (q_full),
        .in_ready (s_ready),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Decoupling queue
    sfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Conversion and result output
    sfd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_field_id    (m_field_id),
        .m_field_index (m_field_index),
        .m_field_value (m_field_value),
        .m_plausible   (m_plausible),
        .m_error_code  (m_error_code),
        .m_last        (m_last)
    );

endmodule
